[hdl/tcd_pkg.sv]
// tcd_pkg: shared constants, codes and types of the textured wall column drawer.
// No dependencies; every other file in hdl/ refers to it by scoped names.

package tcd_pkg;

	// Parameter defaults
	localparam int TEX_SIZE_DEF     = 64;
	localparam int NUM_TEXTURES_DEF = 4;

	// Clamp for the number of rows in one column
	localparam int MAX_ROWS = 1024;

	// Field widths
	localparam int OP_W      = 2;
	localparam int TSEL_W    = 2;
	localparam int TADDR_W   = 12;
	localparam int COLOR_W   = 24;
	localparam int POS_W     = 26;
	localparam int RAY_W     = 18;
	localparam int WALL_W    = 16;
	localparam int ROW_W     = 10;
	localparam int HEIGHT_W  = 11;
	localparam int DIVISOR_W = WALL_W + 1;

	// Shared multiplier operands and kept product width
	localparam int MUL_A_W = 27;
	localparam int MUL_B_W = 18;
	localparam int FRAC_W  = 32;

	// Start offset (span_start - H/2 + wall/2), signed
	localparam int BASE_W = 18;

	// Register port
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CEILING_COLOR = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FLOOR_COLOR   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CAMERA_X      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CAMERA_Y      = 3'd4;

	localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RST = 11'd480;

	// Item opcodes
	localparam logic [OP_W-1:0] OP_WRITE_TEXEL = 2'd0;
	localparam logic [OP_W-1:0] OP_SET_UP      = 2'd1;
	localparam logic [OP_W-1:0] OP_DRAW_ROW    = 2'd2;

	// Column set-up sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HIT,
		ST_COL,
		ST_DIV,
		ST_POS,
		ST_DONE
	} seq_state_t;

	// Source of a pixel's colour
	typedef enum logic [1:0] {
		PIX_CEILING,
		PIX_TEXEL,
		PIX_FLOOR,
		PIX_BLANK
	} pix_kind_t;

endpackage

[hdl/tcd_mul.sv]
// tcd_mul: shared signed multiplier with a registered, truncated product.
// Depends on tcd_pkg for operand and product widths.

module tcd_mul (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [tcd_pkg::MUL_A_W-1:0] a,
	input  logic signed [tcd_pkg::MUL_B_W-1:0] b,
	output logic        [tcd_pkg::FRAC_W-1:0]  p_q
);

	logic signed [tcd_pkg::MUL_A_W+tcd_pkg::MUL_B_W-1:0] prod;

	assign prod = a * b;

	// Only the low word is ever needed (positions wrap modulo 2^32)
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= prod[tcd_pkg::FRAC_W-1:0];
		end
	end

endmodule

[hdl/tcd_div.sv]
// tcd_div: restoring divider of a fixed dividend by a signal, one quotient bit per cycle.
// Depends on tcd_pkg for the divisor width.

module tcd_div #(
	parameter int DIVIDEND = tcd_pkg::TEX_SIZE_DEF,
	parameter int QW       = $clog2(tcd_pkg::TEX_SIZE_DEF) + 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tcd_pkg::DIVISOR_W-1:0]   divisor,
	output logic                            done,
	output logic [QW-1:0]                   quotient
);

	localparam int DW = tcd_pkg::DIVISOR_W;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0] dvd_q;
	logic [QW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW-1:0] shifted;
	logic          fits;
	logic [DW-1:0] rem_nx;

	// One restoring step: bring down the next dividend bit, subtract if it fits.
	// The remainder stays below the divisor, so its top bit is always clear.
	always_comb begin
		shifted = {rem_q[DW-2:0], dvd_q[QW-1]};
		fits    = (shifted >= dsr_q);
		rem_nx  = fits ? (shifted - dsr_q) : shifted;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= QW'(DIVIDEND);
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hdl/tcd_tex_mem.sv]
// tcd_tex_mem: texel store, one write port and one registered read port.
// Depends on tcd_pkg for the texel width.

module tcd_tex_mem #(
	parameter int DEPTH = tcd_pkg::NUM_TEXTURES_DEF * tcd_pkg::TEX_SIZE_DEF * tcd_pkg::TEX_SIZE_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [tcd_pkg::COLOR_W-1:0]   wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [tcd_pkg::COLOR_W-1:0]   rdata_q
);

	logic [tcd_pkg::COLOR_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

[hdl/textured_wall_column_drawer.sv]
// textured_wall_column_drawer: top level, register port, set-up sequencer, row engine.
// Depends on tcd_pkg, tcd_mul, tcd_div and tcd_tex_mem.
//
// Usage. Items enter on item_valid/item_ready, pixels leave on pixel_valid/pixel_ready.
// A write-texel word stores one texel if its texture and address are in range. A
// set-up word latches the ray and span and then runs the column set-up: the shared
// multiplier forms the hit coordinate, the serial divider produces the step
// TEX_SIZE/(wall_height+1) one quotient bit per cycle, and the multiplier is used
// again for the start position. Set-up holds item_ready low until the sequencer is
// back in its idle state. Each draw-row word yields one pixel, top row first; rows
// stream at one per cycle while the receiver takes each pixel, and pixel_valid rises
// in the cycle after acceptance. A draw word past the bottom row, and an unknown
// opcode, yield nothing. A pixel waiting on a stalled receiver stays in the output
// stage and blocks new items until it is taken.
// Registers (APB, 4-byte spacing): screen_height, ceiling_color, floor_color,
// camera_x, camera_y; write them only while the block is idle.
// Reset clears the sequencer, the output stage and the column state and loads the
// register defaults; the texel store is not cleared and must be written before use.

module textured_wall_column_drawer #(
	parameter int TEX_SIZE     = tcd_pkg::TEX_SIZE_DEF,
	parameter int NUM_TEXTURES = tcd_pkg::NUM_TEXTURES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Register port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tcd_pkg::APB_AW-1:0]         paddr,
	input  logic [tcd_pkg::APB_DW-1:0]         pwdata,
	output logic [tcd_pkg::APB_DW-1:0]         prdata,
	output logic                               pready,
	// Item channel
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [tcd_pkg::OP_W-1:0]           op,
	input  logic [tcd_pkg::TSEL_W-1:0]         tex_select,
	input  logic [tcd_pkg::TADDR_W-1:0]        texel_addr,
	input  logic [tcd_pkg::COLOR_W-1:0]        texel_value,
	input  logic                               hit_side,
	input  logic signed [tcd_pkg::RAY_W-1:0]   ray_dir_x,
	input  logic signed [tcd_pkg::RAY_W-1:0]   ray_dir_y,
	input  logic [tcd_pkg::POS_W-1:0]          ray_dist,
	input  logic [tcd_pkg::WALL_W-1:0]         wall_height,
	input  logic [tcd_pkg::ROW_W-1:0]          span_start,
	input  logic [tcd_pkg::ROW_W-1:0]          span_end,
	// Pixel channel
	output logic                               pixel_valid,
	input  logic                               pixel_ready,
	output logic [tcd_pkg::ROW_W-1:0]          pixel_row,
	output logic [tcd_pkg::COLOR_W-1:0]        pixel_color,
	output logic                               last_row
);

	localparam int TEX_LOG     = $clog2(TEX_SIZE);
	localparam int TEX_AW      = 2 * TEX_LOG;
	localparam int TEX_AREA    = TEX_SIZE * TEX_SIZE;
	localparam int STORE_DEPTH = NUM_TEXTURES * TEX_AREA;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int TEX_IW      = (NUM_TEXTURES > 1) ? $clog2(NUM_TEXTURES) : 1;
	localparam int FULL_AW     = TEX_IW + TEX_AW;
	localparam int STEP_W      = TEX_LOG + 1;

	localparam int HW = tcd_pkg::HEIGHT_W;
	localparam int CW = tcd_pkg::COLOR_W;
	localparam int BW = tcd_pkg::BASE_W;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [HW-1:0]                 screen_height_q;
	logic [CW-1:0]                 ceiling_color_q;
	logic [CW-1:0]                 floor_color_q;
	logic [tcd_pkg::POS_W-1:0]     camera_x_q;
	logic [tcd_pkg::POS_W-1:0]     camera_y_q;

	logic                          cfg_we;
	logic [tcd_pkg::REG_IDX_W-1:0] reg_idx;

	assign cfg_we  = psel & penable & pwrite;
	assign reg_idx = paddr[tcd_pkg::APB_AW-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_height_q <= tcd_pkg::SCREEN_HEIGHT_RST;
			ceiling_color_q <= '0;
			floor_color_q   <= '0;
			camera_x_q      <= '0;
			camera_y_q      <= '0;
		end else if (cfg_we) begin
			case (reg_idx)
				tcd_pkg::REG_SCREEN_HEIGHT: screen_height_q <= pwdata[HW-1:0];
				tcd_pkg::REG_CEILING_COLOR: ceiling_color_q <= pwdata[CW-1:0];
				tcd_pkg::REG_FLOOR_COLOR:   floor_color_q   <= pwdata[CW-1:0];
				tcd_pkg::REG_CAMERA_X:      camera_x_q      <= pwdata[tcd_pkg::POS_W-1:0];
				tcd_pkg::REG_CAMERA_Y:      camera_y_q      <= pwdata[tcd_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back
	always_comb begin
		case (reg_idx)
			tcd_pkg::REG_SCREEN_HEIGHT: prdata = tcd_pkg::APB_DW'(screen_height_q);
			tcd_pkg::REG_CEILING_COLOR: prdata = tcd_pkg::APB_DW'(ceiling_color_q);
			tcd_pkg::REG_FLOOR_COLOR:   prdata = tcd_pkg::APB_DW'(floor_color_q);
			tcd_pkg::REG_CAMERA_X:      prdata = tcd_pkg::APB_DW'(camera_x_q);
			tcd_pkg::REG_CAMERA_Y:      prdata = tcd_pkg::APB_DW'(camera_y_q);
			default:                    prdata = '0;
		endcase
	end

	// Rows per column, clamped
	logic [HW-1:0] eff_h;
	assign eff_h = (screen_height_q > HW'(tcd_pkg::MAX_ROWS)) ?
		HW'(tcd_pkg::MAX_ROWS) : screen_height_q;

	// ---------------------------------------------------------------------
	// Column state and latched set-up word
	// ---------------------------------------------------------------------
	tcd_pkg::seq_state_t state_q, state_d;

	logic [HW-1:0]                   row_q;
	logic [TEX_LOG-1:0]              column_q;
	logic [STEP_W-1:0]               step_q;
	logic [tcd_pkg::FRAC_W-1:0]      position_q;
	logic [TEX_IW-1:0]               act_tex_q;
	logic                            act_ok_q;
	logic [tcd_pkg::ROW_W-1:0]       span_start_q;
	logic [tcd_pkg::ROW_W-1:0]       span_end_q;

	logic                            side_q;
	logic signed [tcd_pkg::RAY_W-1:0] rx_q;
	logic signed [tcd_pkg::RAY_W-1:0] ry_q;
	logic [tcd_pkg::POS_W-1:0]       dist_q;
	logic [tcd_pkg::WALL_W-1:0]      wall_q;

	// Output stage
	logic                            s1_valid_q;
	logic [tcd_pkg::ROW_W-1:0]       row_s1;
	tcd_pkg::pix_kind_t              kind_s1;
	logic                            last_s1;

	// ---------------------------------------------------------------------
	// Item handshake and decode
	// ---------------------------------------------------------------------
	logic out_free;
	logic accept;
	logic acc_write;
	logic acc_setup;
	logic acc_draw;

	assign out_free   = !s1_valid_q || pixel_ready;
	assign item_ready = (state_q == tcd_pkg::ST_IDLE) && out_free;
	assign accept     = item_valid && item_ready;
	assign acc_write  = accept && (op == tcd_pkg::OP_WRITE_TEXEL);
	assign acc_setup  = accept && (op == tcd_pkg::OP_SET_UP);
	assign acc_draw   = accept && (op == tcd_pkg::OP_DRAW_ROW);

	logic sel_tex_ok;
	assign sel_tex_ok = (32'(tex_select) < NUM_TEXTURES);

	// ---------------------------------------------------------------------
	// Texel store
	// ---------------------------------------------------------------------
	logic                  wr_addr_ok;
	logic                  mem_we;
	logic [FULL_AW-1:0]    wr_full;
	logic [FULL_AW-1:0]    rd_full;
	logic                  mem_re;
	logic [CW-1:0]         mem_rdata;

	assign wr_addr_ok = (32'(texel_addr) < TEX_AREA);
	assign mem_we     = acc_write && sel_tex_ok && wr_addr_ok;
	assign wr_full    = {TEX_IW'(tex_select), TEX_AW'(texel_addr)};
	assign rd_full    = {act_tex_q, position_q[TEX_LOG-1:0], column_q};

	tcd_tex_mem #(
		.DEPTH (STORE_DEPTH),
		.AW    (STORE_AW)
	) u_tex_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (wr_full[STORE_AW-1:0]),
		.wdata   (texel_value),
		.re      (mem_re),
		.raddr   (rd_full[STORE_AW-1:0]),
		.rdata_q (mem_rdata)
	);

	// ---------------------------------------------------------------------
	// Row engine: classify the current row
	// ---------------------------------------------------------------------
	logic               has_row;
	logic               in_ceiling;
	logic               in_wall;
	logic               tex_row;
	tcd_pkg::pix_kind_t kind_d;

	assign has_row    = (row_q < eff_h);
	assign in_ceiling = (row_q < HW'(span_start_q));
	assign in_wall    = (row_q <= HW'(span_end_q));
	assign tex_row    = !in_ceiling && in_wall;
	assign mem_re     = acc_draw && has_row && tex_row && act_ok_q;

	always_comb begin
		if (in_ceiling) begin
			kind_d = tcd_pkg::PIX_CEILING;
		end else if (in_wall) begin
			kind_d = act_ok_q ? tcd_pkg::PIX_TEXEL : tcd_pkg::PIX_BLANK;
		end else begin
			kind_d = tcd_pkg::PIX_FLOOR;
		end
	end

	// ---------------------------------------------------------------------
	// Shared multiplier and step divider
	// ---------------------------------------------------------------------
	logic                                 mul_en;
	logic signed [tcd_pkg::MUL_A_W-1:0]   mul_a;
	logic signed [tcd_pkg::MUL_B_W-1:0]   mul_b;
	logic [tcd_pkg::FRAC_W-1:0]           mul_p;
	logic                                 div_start;
	logic                                 div_done;
	logic [STEP_W-1:0]                    div_q;

	tcd_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	tcd_div #(
		.DIVIDEND (TEX_SIZE),
		.QW       (STEP_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (tcd_pkg::DIVISOR_W'(wall_q) + 1'b1),
		.done     (div_done),
		.quotient (div_q)
	);

	// Start offset span_start - H/2 + wall/2
	logic signed [BW-1:0] base;
	assign base = $signed(BW'(span_start_q)) - $signed(BW'(eff_h[HW-1:1]))
		+ $signed(BW'(wall_q[tcd_pkg::WALL_W-1:1]));

	// Hit fraction and texture column
	logic [tcd_pkg::POS_W-1:0]  cam_sel;
	logic [tcd_pkg::FRAC_W-1:0] frac;
	logic [TEX_LOG-1:0]         col_raw;
	logic                       mirror;

	assign cam_sel = side_q ? camera_x_q : camera_y_q;
	assign frac    = {cam_sel[15:0], 16'h0000} + mul_p;
	assign col_raw = frac[tcd_pkg::FRAC_W-1 -: TEX_LOG];
	assign mirror  = (!side_q && !rx_q[tcd_pkg::RAY_W-1] && (rx_q != '0))
		|| (side_q && ry_q[tcd_pkg::RAY_W-1]);

	// ---------------------------------------------------------------------
	// Set-up sequencer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		case (state_q)
			tcd_pkg::ST_IDLE: begin
				if (acc_setup) begin
					state_d = tcd_pkg::ST_HIT;
				end
			end
			tcd_pkg::ST_HIT: begin
				// dist * ray, low word only
				mul_en  = 1'b1;
				mul_a   = $signed({1'b0, dist_q});
				mul_b   = side_q ? rx_q : ry_q;
				state_d = tcd_pkg::ST_COL;
			end
			tcd_pkg::ST_COL: begin
				div_start = 1'b1;
				state_d   = tcd_pkg::ST_DIV;
			end
			tcd_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = tcd_pkg::ST_POS;
				end
			end
			tcd_pkg::ST_POS: begin
				// base * step, low word only
				mul_en  = 1'b1;
				mul_a   = {{(tcd_pkg::MUL_A_W-BW){base[BW-1]}}, base};
				mul_b   = $signed(tcd_pkg::MUL_B_W'(step_q));
				state_d = tcd_pkg::ST_DONE;
			end
			tcd_pkg::ST_DONE: begin
				state_d = tcd_pkg::ST_IDLE;
			end
			default: begin
				state_d = tcd_pkg::ST_IDLE;
			end
		endcase
	end

	// Column state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q        <= '0;
			column_q     <= '0;
			step_q       <= '0;
			position_q   <= '0;
			act_tex_q    <= '0;
			act_ok_q     <= 1'b1;
			span_start_q <= '0;
			span_end_q   <= '0;
		end else begin
			if (acc_setup) begin
				row_q        <= '0;
				act_tex_q    <= TEX_IW'(tex_select);
				act_ok_q     <= sel_tex_ok;
				span_start_q <= span_start;
				span_end_q   <= span_end;
			end
			if (acc_draw && has_row) begin
				row_q <= row_q + 1'b1;
				if (tex_row) begin
					position_q <= position_q + tcd_pkg::FRAC_W'(step_q);
				end
			end
			if (state_q == tcd_pkg::ST_COL) begin
				column_q <= mirror ? ~col_raw : col_raw;
			end
			if ((state_q == tcd_pkg::ST_DIV) && div_done) begin
				step_q <= div_q;
			end
			if (state_q == tcd_pkg::ST_DONE) begin
				position_q <= mul_p;
			end
		end
	end

	// Latched set-up word
	always_ff @(posedge clk) begin
		if (acc_setup) begin
			side_q <= hit_side;
			rx_q   <= ray_dir_x;
			ry_q   <= ray_dir_y;
			dist_q <= ray_dist;
			wall_q <= wall_height;
		end
	end

	// ---------------------------------------------------------------------
	// Output stage
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc_draw && has_row) begin
			s1_valid_q <= 1'b1;
		end else if (pixel_ready) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_draw && has_row) begin
			row_s1  <= row_q[tcd_pkg::ROW_W-1:0];
			kind_s1 <= kind_d;
			last_s1 <= ((row_q + 1'b1) == eff_h);
		end
	end

	always_comb begin
		case (kind_s1)
			tcd_pkg::PIX_CEILING: pixel_color = ceiling_color_q;
			tcd_pkg::PIX_TEXEL:   pixel_color = mem_rdata;
			tcd_pkg::PIX_FLOOR:   pixel_color = floor_color_q;
			default:              pixel_color = '0;
		endcase
	end

	assign pixel_valid = s1_valid_q;
	assign pixel_row   = row_s1;
	assign last_row    = last_s1;

endmodule

[hdl/tcd_checker.sv]
// tcd_checker: port-level assertions for the textured wall column drawer, bound to it.
// Depends on tcd_pkg for field widths and opcodes.

module tcd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic [tcd_pkg::OP_W-1:0]      op,
	input logic                          pixel_valid,
	input logic                          pixel_ready,
	input logic [tcd_pkg::ROW_W-1:0]     pixel_row,
	input logic [tcd_pkg::COLOR_W-1:0]   pixel_color,
	input logic                          last_row
);

	// A stalled pixel keeps its word
	a_pixel_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_row)
			&& $stable(pixel_color) && $stable(last_row))
		else $error("stalled pixel changed");

	// Column set-up occupies the block after it is taken
	a_setup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (op == tcd_pkg::OP_SET_UP) |=> !item_ready)
		else $error("item taken right after a set-up word");

	// No item is taken while a pixel waits on the receiver
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && !pixel_ready |-> !item_ready)
		else $error("item taken while output is stalled");

	// Only a draw word can bring up a pixel
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (op != tcd_pkg::OP_DRAW_ROW) && !pixel_valid
			|=> !pixel_valid)
		else $error("pixel without a draw word");

endmodule

bind textured_wall_column_drawer tcd_checker u_tcd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.op          (op),
	.pixel_valid (pixel_valid),
	.pixel_ready (pixel_ready),
	.pixel_row   (pixel_row),
	.pixel_color (pixel_color),
	.last_row    (last_row)
);
